/* design/wdf_pkg.sv */
package wdf_pkg;

  localparam int WINDOW         = 20;
  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC_BITS = 16;

  // Register widths are fixed by the register map.
  localparam int TAPS_W = 5;
  localparam int GAIN_W = 16;
  localparam int TAPS_N = 1 << TAPS_W;

  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(20);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3277);

  localparam int POS_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int STRIDE_W = $clog2(WINDOW + 1);
  localparam int ACC_W  = 40;
  localparam int PROD_W = ACC_W + GAIN_W;
  localparam int Q_W    = PROD_W - GAIN_FRAC_BITS;

  localparam int MUL_CNT_W = $clog2(GAIN_W + 1);
  localparam int MOD_CNT_W = $clog2(POS_W + 1);

  typedef enum logic [0:0] {
    REG_TAPS = 1'b0,
    REG_GAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FINAL,
    ST_SCALE,
    ST_SAT,
    ST_EMIT
  } wdf_state_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  multiplicand;
    logic [GAIN_W-1:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic                start;
    logic [POS_W-1:0]    dividend;
    logic [STRIDE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } mod_rsp_t;

  typedef logic [STRIDE_W-1:0] stride_tab_t [TAPS_N];

  // Stride for each tap count, worked out once at elaboration.
  function automatic stride_tab_t build_stride_tab();
    stride_tab_t tab;
    int t;
    int q;
    for (int i = 0; i < TAPS_N; i++) begin
      t = (i == 0) ? 1 : i;
      if (t > WINDOW) t = WINDOW;
      q = 0;
      for (int k = 1; k <= WINDOW; k++) begin
        if (k * t <= WINDOW) q = k;
      end
      tab[i] = STRIDE_W'(q);
    end
    return tab;
  endfunction

  localparam stride_tab_t STRIDE_TAB = build_stride_tab();

endpackage

/* design/windowed_decimating_fir.sv */
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   in_tdata: sample_value; in_tuser: frame_start
// out_      master     out_tvalid/out_tready out_tdata: filtered_value
// cfg_      slave      cfg_valid/cfg_ready   cfg_index: register, cfg_data: value
//
// An item is accepted, goes through the shared shift-add multiplier (one gain bit
// per cycle), and then has its tap product added into the accumulator. For the last
// item of a window the accumulator then goes through the same multiplier once more,
// bit by bit, for the stride scaling. With one tap (or a tap count of zero) there
// is no scaling.
// Reset is synchronous and active low; it clears the window and loads the
// register defaults. A waiting result in the output register does not stop the
// next item being taken; only a second result finding it still full stalls.
module windowed_decimating_fir (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input items.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wdf_pkg::SAMPLE_BITS-1:0] in_tdata,  // [15:0] sample_value
  input  logic [0:0]                    in_tuser,  // [0] frame_start
  // Result items.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wdf_pkg::SAMPLE_BITS-1:0] out_tdata, // [15:0] filtered_value
  // Register writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [wdf_pkg::GAIN_W-1:0]    cfg_data
);
  import wdf_pkg::*;

  wdf_state_t state_r, state_nxt;

  logic [TAPS_W-1:0]      taps_r;
  logic [GAIN_W-1:0]      gain_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0] hold_r, hold_nxt;
  logic [STRIDE_W-1:0]    stride_r, stride_nxt;
  logic                   single_r, single_nxt;
  logic                   last_r, last_nxt;
  logic [SAMPLE_BITS-1:0] result_r, result_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic                   in_acc;
  logic                   emit_load;
  logic [POS_W-1:0]       pos_eff;
  logic [PROD_W-1:0]      biased;
  logic [Q_W-1:0]         quot;
  logic [Q_W-SAMPLE_BITS:0] quot_hi;
  logic                   fits;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign pos_eff   = in_tuser[0] ? '0 : pos_r;

  // Truncation toward zero: a negative total is biased up before the shift.
  assign biased  = mul_rsp.product
                 + (mul_rsp.product[PROD_W-1] ?
                    PROD_W'({GAIN_FRAC_BITS{1'b1}}) : PROD_W'(0));
  assign quot    = biased[PROD_W-1:GAIN_FRAC_BITS];
  assign quot_hi = quot[Q_W-1:SAMPLE_BITS-1];
  assign fits    = (&quot_hi) || !(|quot_hi);

  wdf_shift_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  wdf_pos_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    hold_nxt   = hold_r;
    stride_nxt = stride_r;
    single_nxt = single_r;
    last_nxt   = last_r;
    result_nxt = result_r;
    emit_load  = 1'b0;
    mul_req    = '0;
    mod_req    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // A frame start drops any partial window before this sample.
          if (in_tuser[0]) begin
            acc_nxt = '0;
          end
          if (pos_eff == '0) begin
            hold_nxt = in_tdata;
          end
          stride_nxt = STRIDE_TAB[taps_r];
          single_nxt = (taps_r <= TAPS_W'(1));
          last_nxt   = (pos_eff == POS_W'(WINDOW - 1));
          pos_nxt    = pos_eff;
          mul_req.start        = 1'b1;
          mul_req.multiplicand = {{(ACC_W-SAMPLE_BITS){in_tdata[SAMPLE_BITS-1]}}, in_tdata};
          mul_req.multiplier   = gain_r;
          mod_req.start        = 1'b1;
          mod_req.dividend     = pos_eff;
          mod_req.divisor      = STRIDE_TAB[taps_r];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!mul_rsp.busy) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // Only positions on the stride grid contribute.
        if (mod_rsp.zero) begin
          acc_nxt = acc_r + mul_rsp.product[ACC_W-1:0];
        end
        if (last_r) begin
          state_nxt = ST_FINAL;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FINAL: begin
        pos_nxt = '0;
        acc_nxt = '0;
        if (single_r) begin
          result_nxt = hold_r;
          state_nxt  = ST_EMIT;
        end else begin
          mul_req.start        = 1'b1;
          mul_req.multiplicand = acc_r;
          mul_req.multiplier   = GAIN_W'(stride_r);
          state_nxt            = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!mul_rsp.busy) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (fits) begin
          result_nxt = quot[SAMPLE_BITS-1:0];
        end else if (quot[Q_W-1]) begin
          result_nxt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
          result_nxt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      taps_r      <= TAPS_RESET;
      gain_r      <= GAIN_RESET;
      pos_r       <= '0;
      acc_r       <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TAPS: taps_r <= cfg_data[TAPS_W-1:0];
          REG_GAIN: gain_r <= cfg_data;
          default:  taps_r <= taps_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stride_r   <= stride_nxt;
    single_r   <= single_nxt;
    last_r     <= last_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_mul_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mul_rsp.busy)
    else $error("multiplier still busy while taking items");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW - 1))
    else $error("window position beyond the window");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (acc_r == '0 && pos_r == '0))
    else $error("window not cleared before its result leaves");

  a_mod_before_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> !mod_rsp.busy)
    else $error("tap decision not ready at accumulation");
`endif

endmodule

/* design/wdf_shift_mul.sv */
module wdf_shift_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  wdf_pkg::mul_req_t req,
  output wdf_pkg::mul_rsp_t rsp
);
  import wdf_pkg::*;

  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [GAIN_W-1:0]    mplier_r, mplier_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;

  // One multiplier bit per cycle, least significant first.
  always_comb begin
    mcand_nxt  = mcand_r;
    prod_nxt   = prod_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    if (req.start) begin
      mcand_nxt  = {{(PROD_W-ACC_W){req.multiplicand[ACC_W-1]}}, req.multiplicand};
      prod_nxt   = '0;
      mplier_nxt = req.multiplier;
      cnt_nxt    = MUL_CNT_W'(GAIN_W);
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) begin
        prod_nxt = prod_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    prod_r   <= prod_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.busy    = (cnt_r != '0);
  assign rsp.product = prod_r;

endmodule

/* design/wdf_pos_mod.sv */
module wdf_pos_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  wdf_pkg::mod_req_t req,
  output wdf_pkg::mod_rsp_t rsp
);
  import wdf_pkg::*;

  logic [POS_W-1:0]     dvd_r, dvd_nxt;
  logic [STRIDE_W-1:0]  dsr_r, dsr_nxt;
  logic [STRIDE_W-1:0]  rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STRIDE_W:0]    shifted;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    shifted = {rem_r, dvd_r[POS_W-1]};
    if (req.start) begin
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = MOD_CNT_W'(POS_W);
    end else if (cnt_r != '0) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = STRIDE_W'(shifted - {1'b0, dsr_r});
      end else begin
        rem_nxt = shifted[STRIDE_W-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.zero = (rem_r == '0);

endmodule
